[design/falling_sand_cell_update_macros.svh]
// Assertion macros for the falling-sand cell update block.
// Included by the modules that carry concurrent checks; no other dependencies.
`ifndef FALLING_SAND_CELL_UPDATE_MACROS_SVH
`define FALLING_SAND_CELL_UPDATE_MACROS_SVH
`ifndef SYNTH
`define FSC_ASSERT(lbl, clk, rst_n, prop, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);
`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);
`else
`define FSC_ASSERT(lbl, clk, rst_n, prop, msg)
`define FSC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg)
`endif
`endif

[design/fsc_pkg.sv]
// Shared types, constants and codes for the falling-sand cell update block.
// No dependencies; imported by every module of the block.
package fsc_pkg;

    localparam int GRID_SIZE  = 256;
    localparam int COORD_W    = $clog2(GRID_SIZE);
    localparam int GRID_DEPTH = GRID_SIZE * GRID_SIZE;
    localparam int ADDR_W     = $clog2(GRID_DEPTH);
    localparam int POS_W      = ((COORD_W > 8) ? COORD_W : 8) + 2;

    typedef logic [1:0] t_mat;
    localparam t_mat MAT_EMPTY = 2'd0;
    localparam t_mat MAT_SAND  = 2'd1;
    localparam t_mat MAT_BRICK = 2'd2;
    localparam t_mat MAT_WATER = 2'd3;

    localparam logic [1:0] CMD_PAINT  = 2'd0;
    localparam logic [1:0] CMD_UPDATE = 2'd1;
    localparam logic [1:0] CMD_READ   = 2'd2;

    localparam logic [1:0] KIND_NONE = 2'd0;
    localparam logic [1:0] KIND_DOWN = 2'd1;
    localparam logic [1:0] KIND_DIAG = 2'd2;
    localparam logic [1:0] KIND_SIDE = 2'd3;

    localparam logic [1:0] CFG_SAND_DENS  = 2'd0;
    localparam logic [1:0] CFG_WATER_DENS = 2'd1;
    localparam logic [1:0] CFG_BRICK_DENS = 2'd2;

    localparam logic [1:0] DIR_ZERO = 2'b00;
    localparam logic [1:0] DIR_PLUS = 2'b01;

    // which cell relative to the addressed one is probed
    typedef enum logic [1:0] {
        PR_CTR  = 2'd0,
        PR_DOWN = 2'd1,
        PR_DIAG = 2'd2,
        PR_SIDE = 2'd3
    } t_probe;

    typedef struct packed {
        t_probe     probe;
        logic [7:0] x;
        logic [7:0] y;
        logic [1:0] dir;
    } t_probe_req;

    typedef struct packed {
        logic              inb;
        logic [ADDR_W-1:0] addr;
    } t_probe_res;

    typedef struct packed {
        logic              we;
        logic [ADDR_W-1:0] addr;
        t_mat              wdata;
    } t_mem_req;

endpackage

[design/fsc_grid_mem.sv]
// Single-port grid store, one material code per cell, registered read.
// Depends on fsc_pkg.
module fsc_grid_mem (
    input  logic             i_clk,
    input  fsc_pkg::t_mem_req i_req,
    output fsc_pkg::t_mat    o_rdata
);
    import fsc_pkg::*;

    t_mat r_mem [GRID_DEPTH];
    t_mat r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        r_rdata <= r_mem[i_req.addr];
    end

    assign o_rdata = r_rdata;

endmodule

[design/fsc_probe.sv]
// Shared address unit: neighbor position, bounds check and cell address.
// Depends on fsc_pkg.
module fsc_probe (
    input  fsc_pkg::t_probe_req i_req,
    output fsc_pkg::t_probe_res o_res
);
    import fsc_pkg::*;

    logic [POS_W-1:0] dx;
    logic [POS_W-1:0] xoff;
    logic             dy;
    logic [POS_W-1:0] px;
    logic [POS_W-1:0] py;

    always_comb begin
        if (i_req.dir == DIR_PLUS) begin
            dx = POS_W'(1);
        end else if (i_req.dir == DIR_ZERO) begin
            dx = '0;
        end else begin
            dx = '1;
        end
        unique case (i_req.probe)
            PR_CTR: begin
                xoff = '0;
                dy   = 1'b0;
            end
            PR_DOWN: begin
                xoff = '0;
                dy   = 1'b1;
            end
            PR_DIAG: begin
                xoff = dx;
                dy   = 1'b1;
            end
            PR_SIDE: begin
                xoff = dx;
                dy   = 1'b0;
            end
            default: begin
                xoff = '0;
                dy   = 1'b0;
            end
        endcase
        px = {{(POS_W-8){1'b0}}, i_req.x} + xoff;
        py = {{(POS_W-8){1'b0}}, i_req.y} + POS_W'(dy);
        o_res.inb  = !px[POS_W-1] && !py[POS_W-1]
                   && (px < POS_W'(GRID_SIZE)) && (py < POS_W'(GRID_SIZE));
        o_res.addr = ADDR_W'(py[COORD_W-1:0]) * ADDR_W'(GRID_SIZE)
                   + ADDR_W'(px[COORD_W-1:0]);
    end

endmodule

[design/fsc_ctrl.sv]
// Sequencer: clear pass, command decode, probe reads, swap writes, result register.
// Depends on fsc_pkg and falling_sand_cell_update_macros.svh.
`include "falling_sand_cell_update_macros.svh"
module fsc_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_cfg_we,
    input  logic [1:0]          i_cfg_index,
    input  logic [7:0]          i_cfg_data,
    input  logic                i_in_valid,
    output logic                o_in_ready,
    input  logic [1:0]          i_cmd,
    input  logic [7:0]          i_cell_x,
    input  logic [7:0]          i_cell_y,
    input  logic [1:0]          i_paint_material,
    input  logic signed [1:0]   i_rand_dir,
    output logic                o_out_valid,
    input  logic                i_out_ready,
    output logic [1:0]          o_cell_material,
    output logic                o_moved,
    output logic [1:0]          o_move_kind,
    output fsc_pkg::t_probe_req o_probe_req,
    input  fsc_pkg::t_probe_res i_probe_res,
    output fsc_pkg::t_mem_req   o_mem_req,
    input  fsc_pkg::t_mat       i_rdata
);
    import fsc_pkg::*;

    typedef enum logic [6:0] {
        ST_CLEAR  = 7'b0000001,
        ST_IDLE   = 7'b0000010,
        ST_READ   = 7'b0000100,
        ST_EVAL   = 7'b0001000,
        ST_WR_TGT = 7'b0010000,
        ST_WR_CTR = 7'b0100000,
        ST_DONE   = 7'b1000000
    } t_state;

    t_state            r_state;
    logic [ADDR_W-1:0] r_clr;
    logic [7:0]        r_sand_dens;
    logic [7:0]        r_water_dens;
    logic [7:0]        r_brick_dens;
    logic [1:0]        r_cmd;
    logic [7:0]        r_x;
    logic [7:0]        r_y;
    t_mat              r_paint;
    logic [1:0]        r_dir;
    t_probe            r_probe;
    logic              r_inb;
    t_mat              r_mat;
    t_mat              r_wdata;
    logic [7:0]        r_dens;
    logic              r_diag_ok;
    t_mat              r_diag_mat;
    logic [1:0]        r_kind;
    logic              r_out_valid;
    t_mat              r_out_mat;
    logic              r_out_moved;
    logic [1:0]        r_out_kind;
    logic [7:0]        rd_dens;
    logic              ent;
    logic              out_load;

    function automatic logic [7:0] f_dens(input t_mat m, input logic [7:0] s,
                                          input logic [7:0] w, input logic [7:0] b);
        logic [7:0] d;
        unique case (m)
            MAT_SAND:  d = s;
            MAT_WATER: d = w;
            MAT_BRICK: d = b;
            default:   d = 8'd0;
        endcase
        return d;
    endfunction

    assign rd_dens  = f_dens(i_rdata, r_sand_dens, r_water_dens, r_brick_dens);
    assign ent      = r_inb && ((i_rdata == MAT_EMPTY) || (rd_dens < r_dens));
    assign out_load = (r_state == ST_DONE) && (!r_out_valid || i_out_ready);

    assign o_in_ready      = (r_state == ST_IDLE);
    assign o_out_valid     = r_out_valid;
    assign o_cell_material = r_out_mat;
    assign o_moved         = r_out_moved;
    assign o_move_kind     = r_out_kind;

    assign o_probe_req.probe = r_probe;
    assign o_probe_req.x     = r_x;
    assign o_probe_req.y     = r_y;
    assign o_probe_req.dir   = r_dir;

    always_comb begin
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = i_probe_res.addr;
        o_mem_req.wdata = MAT_EMPTY;
        unique case (r_state)
            ST_CLEAR: begin
                o_mem_req.we   = 1'b1;
                o_mem_req.addr = r_clr;
            end
            ST_WR_TGT: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = r_mat;
            end
            ST_WR_CTR: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = r_wdata;
            end
            default: begin
                o_mem_req.we = 1'b0;
            end
        endcase
    end

    // configuration
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sand_dens  <= 8'd2;
            r_water_dens <= 8'd1;
            r_brick_dens <= 8'd99;
        end else if (i_cfg_we) begin
            unique case (i_cfg_index)
                CFG_SAND_DENS:  r_sand_dens  <= i_cfg_data;
                CFG_WATER_DENS: r_water_dens <= i_cfg_data;
                CFG_BRICK_DENS: r_brick_dens <= i_cfg_data;
                default: ;
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= ST_CLEAR;
            r_clr       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
            unique case (r_state)
                ST_CLEAR: begin
                    if (r_clr == ADDR_W'(GRID_DEPTH - 1)) begin
                        r_state <= ST_IDLE;
                    end else begin
                        r_clr <= r_clr + ADDR_W'(1);
                    end
                end
                ST_IDLE: begin
                    if (i_in_valid) begin
                        r_state <= ST_READ;
                    end
                end
                ST_READ: begin
                    if (r_probe == PR_CTR && !i_probe_res.inb) begin
                        r_state <= ST_DONE;
                    end else begin
                        r_state <= ST_EVAL;
                    end
                end
                ST_EVAL: begin
                    unique case (r_probe)
                        PR_CTR: begin
                            if (r_cmd == CMD_PAINT) begin
                                r_state <= ST_WR_CTR;
                            end else if (r_cmd == CMD_UPDATE &&
                                         (i_rdata == MAT_SAND || i_rdata == MAT_WATER)) begin
                                r_state <= ST_READ;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                        PR_DOWN: begin
                            r_state <= ent ? ST_WR_TGT : ST_READ;
                        end
                        PR_DIAG: begin
                            r_state <= ST_READ;
                        end
                        default: begin
                            if ((r_diag_ok && ent) || (r_mat == MAT_WATER && ent)) begin
                                r_state <= ST_WR_TGT;
                            end else begin
                                r_state <= ST_DONE;
                            end
                        end
                    endcase
                end
                ST_WR_TGT: r_state <= ST_WR_CTR;
                ST_WR_CTR: r_state <= ST_DONE;
                ST_DONE: begin
                    if (out_load) begin
                        r_state <= ST_IDLE;
                    end
                end
                default: r_state <= ST_IDLE;
            endcase
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_out_mat   <= r_mat;
            r_out_moved <= (r_kind != KIND_NONE);
            r_out_kind  <= r_kind;
        end
        unique case (r_state)
            ST_IDLE: begin
                r_cmd   <= i_cmd;
                r_x     <= i_cell_x;
                r_y     <= i_cell_y;
                r_paint <= i_paint_material;
                r_dir   <= i_rand_dir;
                r_probe <= PR_CTR;
                r_mat   <= MAT_EMPTY;
                r_kind  <= KIND_NONE;
            end
            ST_READ: begin
                r_inb <= i_probe_res.inb;
            end
            ST_EVAL: begin
                unique case (r_probe)
                    PR_CTR: begin
                        r_mat   <= i_rdata;
                        r_wdata <= r_paint;
                        r_dens  <= rd_dens;
                        // a paint keeps the center probe for its write
                        r_probe <= (r_cmd == CMD_PAINT) ? PR_CTR : PR_DOWN;
                    end
                    PR_DOWN: begin
                        r_wdata <= i_rdata;
                        if (ent) begin
                            r_kind <= KIND_DOWN;
                        end else begin
                            r_probe <= PR_DIAG;
                        end
                    end
                    PR_DIAG: begin
                        r_diag_ok  <= ent;
                        r_diag_mat <= i_rdata;
                        r_probe    <= PR_SIDE;
                    end
                    default: begin
                        if (r_diag_ok && ent) begin
                            r_kind  <= KIND_DIAG;
                            r_wdata <= r_diag_mat;
                            r_probe <= PR_DIAG;
                        end else if (r_mat == MAT_WATER && ent) begin
                            r_kind  <= KIND_SIDE;
                            r_wdata <= i_rdata;
                        end
                    end
                endcase
            end
            ST_WR_TGT: begin
                r_probe <= PR_CTR;
            end
            default: ;
        endcase
    end

    `FSC_ASSERT(a_idle_no_write, i_clk, i_rst_n,
        (r_state == ST_IDLE) |-> !o_mem_req.we, "write while idle")
    `FSC_ASSERT(a_write_in_grid, i_clk, i_rst_n,
        (r_state == ST_WR_TGT || r_state == ST_WR_CTR) |-> i_probe_res.inb,
        "cell write outside grid")
    `FSC_ASSERT(a_moved_kind, i_clk, i_rst_n,
        r_out_valid |-> (r_out_moved == (r_out_kind != KIND_NONE)),
        "moved flag disagrees with move kind")
    `FSC_ASSERT_NEXT(a_done_load, i_clk, i_rst_n, out_load,
        r_out_valid && r_state == ST_IDLE, "result not loaded on completion")

endmodule

[design/falling_sand_cell_update.sv]
// Falling-sand cell store and one-cell update rule: top level.
// Depends on fsc_pkg, fsc_grid_mem, fsc_probe and fsc_ctrl.
// After reset the block clears its GRID_SIZE x GRID_SIZE store and accepts no
// transaction until that pass is done; configuration writes are taken at any
// time. Every transaction is then handled alone and yields one result; an update
// takes longer the more neighbor cells it must probe. The pace is set by the
// single grid memory port: each probed cell is read and then compared, and a
// swap costs two writes, the target cell and then the center cell. A finished
// result waits in an output register, so the next transaction can be accepted
// while it is still pending.
module falling_sand_cell_update (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              i_cfg_we,
    input  logic [1:0]        i_cfg_index,
    input  logic [7:0]        i_cfg_data,
    input  logic              i_in_valid,
    output logic              o_in_ready,
    input  logic [1:0]        i_cmd,
    input  logic [7:0]        i_cell_x,
    input  logic [7:0]        i_cell_y,
    input  logic [1:0]        i_paint_material,
    input  logic signed [1:0] i_rand_dir,
    output logic              o_out_valid,
    input  logic              i_out_ready,
    output logic [1:0]        o_cell_material,
    output logic              o_moved,
    output logic [1:0]        o_move_kind
);
    import fsc_pkg::*;

    t_probe_req probe_req;
    t_probe_res probe_res;
    t_mem_req   mem_req;
    t_mat       rdata;

    fsc_ctrl u_ctrl (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_paint_material (i_paint_material),
        .i_rand_dir       (i_rand_dir),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cell_material  (o_cell_material),
        .o_moved          (o_moved),
        .o_move_kind      (o_move_kind),
        .o_probe_req      (probe_req),
        .i_probe_res      (probe_res),
        .o_mem_req        (mem_req),
        .i_rdata          (rdata)
    );

    fsc_probe u_probe (
        .i_req (probe_req),
        .o_res (probe_res)
    );

    fsc_grid_mem u_mem (
        .i_clk   (i_clk),
        .i_req   (mem_req),
        .o_rdata (rdata)
    );

endmodule

[verif/tb_falling_sand_cell_update.sv]
// Testbench for the falling-sand cell store: paint, read and update transactions.
// A behavioral grid copy predicts results except fixed row_known ones. Depends on fsc_pkg, RTL.
`timescale 1ns / 1ps

module tb_falling_sand_cell_update;
    import fsc_pkg::*;

    localparam logic [1:0] CMD_ALIAS  = 2'd3;
    localparam logic [1:0] CFG_SPARE  = 2'd3;
    localparam logic [1:0] DIR_SAT    = 2'b10;
    localparam logic [1:0] DIR_MINUS  = 2'b11;
    localparam int WIN               = 6;
    localparam int PHASES            = 6;
    localparam int ITEMS_PER_PHASE   = 155;
    localparam int SETTLE_CYCLES     = 16;
    localparam int HOLD_CYCLES       = 400;
    localparam int WATCHDOG_LIMIT    = 200000;

    typedef struct packed {
        logic [1:0] cmd;
        logic [7:0] x;
        logic [7:0] y;
        t_mat       mat;
        logic [1:0] dir;
    } cell_op_t;

    typedef struct packed {
        t_mat       mat;
        logic       moved;
        logic [1:0] kind;
    } move_result_t;

    typedef struct packed {
        cell_op_t     op;
        logic         known;
        move_result_t want;
    } directed_row_t;

    logic              i_clk;
    logic              i_rst_n;
    logic              i_cfg_we;
    logic [1:0]        i_cfg_index;
    logic [7:0]        i_cfg_data;
    logic              i_in_valid;
    logic              o_in_ready;
    logic [1:0]        i_cmd;
    logic [7:0]        i_cell_x;
    logic [7:0]        i_cell_y;
    logic [1:0]        i_paint_material;
    logic signed [1:0] i_rand_dir;
    logic              o_out_valid;
    logic              i_out_ready;
    logic [1:0]        o_cell_material;
    logic              o_moved;
    logic [1:0]        o_move_kind;

    falling_sand_cell_update dut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_cfg_we         (i_cfg_we),
        .i_cfg_index      (i_cfg_index),
        .i_cfg_data       (i_cfg_data),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_cmd            (i_cmd),
        .i_cell_x         (i_cell_x),
        .i_cell_y         (i_cell_y),
        .i_paint_material (i_paint_material),
        .i_rand_dir       (i_rand_dir),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_cell_material  (o_cell_material),
        .o_moved          (o_moved),
        .o_move_kind      (o_move_kind)
    );

    // predictor state
    t_mat       cell_store [0:GRID_SIZE*GRID_SIZE-1];
    logic [7:0] sand_dens;
    logic [7:0] water_dens;
    logic [7:0] brick_dens;

    move_result_t  awaited_results [$];
    directed_row_t directed_rows [$];
    move_result_t  head;

    int  n_errors = 0;
    int  n_sent = 0;
    int  n_checked = 0;
    int  n_updates = 0;
    int  n_down = 0;
    int  n_diag = 0;
    int  n_side = 0;
    int  quiet_cycles = 0;
    int  tx_idle_pct = 0;
    int  rx_idle_pct = 0;
    int  win_x = 0;
    int  win_y = 0;
    bit  drain_hold_req = 1'b0;

    initial begin
        i_clk = 1'b0;
        forever #10 i_clk = ~i_clk;
    end

    function automatic bit on_grid(int cx, int cy);
        return cx >= 0 && cy >= 0 && cx < GRID_SIZE && cy < GRID_SIZE;
    endfunction

    function automatic logic [7:0] density_of_mat(t_mat m);
        case (m)
            MAT_SAND:  return sand_dens;
            MAT_BRICK: return brick_dens;
            MAT_WATER: return water_dens;
            default:   return 8'd0;
        endcase
    endfunction

    function automatic bit can_enter(int cx, int cy, logic [7:0] d);
        t_mat m;
        if (!on_grid(cx, cy)) return 1'b0;
        m = cell_store[cy*GRID_SIZE + cx];
        return m == MAT_EMPTY || density_of_mat(m) < d;
    endfunction

    function automatic void swap_cells(int x0, int y0, int x1, int y1);
        t_mat a;
        a = cell_store[y0*GRID_SIZE + x0];
        cell_store[y0*GRID_SIZE + x0] = cell_store[y1*GRID_SIZE + x1];
        cell_store[y1*GRID_SIZE + x1] = a;
    endfunction

    function automatic move_result_t apply_cell_op(cell_op_t op);
        move_result_t res;
        int           cx;
        int           cy;
        int           r;
        logic [7:0]   d;
        res = '0;
        cx  = op.x;
        cy  = op.y;
        r   = (op.dir == DIR_PLUS) ? 1 : ((op.dir == DIR_ZERO) ? 0 : -1);
        if (on_grid(cx, cy)) begin
            res.mat = cell_store[cy*GRID_SIZE + cx];
            if (op.cmd == CMD_PAINT) begin
                cell_store[cy*GRID_SIZE + cx] = op.mat;
            end else if (op.cmd == CMD_UPDATE &&
                         (res.mat == MAT_SAND || res.mat == MAT_WATER)) begin
                d = density_of_mat(res.mat);
                if (can_enter(cx, cy + 1, d)) begin
                    swap_cells(cx, cy, cx, cy + 1);
                    res.kind = KIND_DOWN;
                end else if (can_enter(cx + r, cy + 1, d) && can_enter(cx + r, cy, d)) begin
                    swap_cells(cx, cy, cx + r, cy + 1);
                    res.kind = KIND_DIAG;
                end else if (res.mat == MAT_WATER && can_enter(cx + r, cy, d)) begin
                    swap_cells(cx, cy, cx + r, cy);
                    res.kind = KIND_SIDE;
                end
                res.moved = res.kind != KIND_NONE;
            end
        end
        return res;
    endfunction

    task automatic row(logic [1:0] cmd, int cx, int cy, t_mat m, logic [1:0] dir);
        directed_row_t e;
        e = '0;
        e.op = '{cmd: cmd, x: cx[7:0], y: cy[7:0], mat: m, dir: dir};
        directed_rows.push_back(e);
    endtask

    // rows whose result is plain: addressed cell content, no move
    task automatic row_known(logic [1:0] cmd, int cx, int cy, t_mat m, logic [1:0] dir,
                             t_mat want_mat);
        directed_row_t e;
        e = '0;
        e.op    = '{cmd: cmd, x: cx[7:0], y: cy[7:0], mat: m, dir: dir};
        e.known = 1'b1;
        e.want  = '{mat: want_mat, moved: 1'b0, kind: KIND_NONE};
        directed_rows.push_back(e);
    endtask

    // called at a falling edge, returns at a falling edge
    task automatic send_cell_op(cell_op_t op, logic known, move_result_t want);
        move_result_t res;
        while ($urandom_range(99) < tx_idle_pct) begin
            i_in_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_in_valid       <= 1'b1;
        i_cmd            <= op.cmd;
        i_cell_x         <= op.x;
        i_cell_y         <= op.y;
        i_paint_material <= op.mat;
        i_rand_dir       <= op.dir;
        @(posedge i_clk);
        while (o_in_ready !== 1'b1) @(posedge i_clk);
        res = apply_cell_op(op);
        awaited_results.push_back(known ? want : res);
        n_sent++;
        if (op.cmd == CMD_UPDATE) n_updates++;
        case (res.kind)
            KIND_DOWN: n_down++;
            KIND_DIAG: n_diag++;
            KIND_SIDE: n_side++;
            default: ;
        endcase
        @(negedge i_clk);
    endtask

    task automatic set_densities(logic [7:0] s, logic [7:0] w, logic [7:0] b);
        i_cfg_we    <= 1'b1;
        i_cfg_index <= CFG_SAND_DENS;
        i_cfg_data  <= s;
        @(negedge i_clk);
        i_cfg_index <= CFG_WATER_DENS;
        i_cfg_data  <= w;
        @(negedge i_clk);
        i_cfg_index <= CFG_BRICK_DENS;
        i_cfg_data  <= b;
        @(negedge i_clk);
        // spare index must be ignored
        i_cfg_index <= CFG_SPARE;
        i_cfg_data  <= 8'($urandom_range(255));
        @(negedge i_clk);
        i_cfg_we <= 1'b0;
        sand_dens  = s;
        water_dens = w;
        brick_dens = b;
    endtask

    task automatic settle();
        while (awaited_results.size() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic pick_window();
        case ($urandom_range(3))
            0: begin
                win_x = 0;
                win_y = GRID_SIZE - WIN;
            end
            1: begin
                win_x = GRID_SIZE - WIN;
                win_y = GRID_SIZE - WIN;
            end
            2: begin
                win_x = $urandom_range(GRID_SIZE - WIN);
                win_y = GRID_SIZE - WIN;
            end
            default: begin
                win_x = $urandom_range(GRID_SIZE - WIN);
                win_y = $urandom_range(GRID_SIZE - WIN);
            end
        endcase
    endtask

    function automatic cell_op_t random_cell_op();
        cell_op_t op;
        int       pick;
        op.dir = 2'($urandom_range(3));
        if ($urandom_range(99) < 12) begin
            op.cmd = 2'($urandom_range(3));
            op.x   = 8'($urandom_range(255));
            op.y   = 8'($urandom_range(255));
            op.mat = t_mat'($urandom_range(3));
            return op;
        end
        pick = $urandom_range(99);
        op.cmd = (pick < 30) ? CMD_PAINT : (pick < 80) ? CMD_UPDATE :
                 (pick < 95) ? CMD_READ : CMD_ALIAS;
        op.x = 8'(win_x + $urandom_range(WIN - 1));
        op.y = 8'(win_y + $urandom_range(WIN - 1));
        pick = $urandom_range(99);
        op.mat = (pick < 40) ? MAT_SAND : (pick < 75) ? MAT_WATER :
                 (pick < 90) ? MAT_BRICK : MAT_EMPTY;
        return op;
    endfunction

    task automatic report_field(string name, int want, int got);
        $display("%0t: %s mismatch, expected %0d, actual %0d", $time, name, want, got);
        n_errors++;
    endtask

    // result checker
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid === 1'b1 && i_out_ready) begin
            if (awaited_results.size() == 0) begin
                $display("%0t: unexpected result, expected none, actual %0d/%0d/%0d",
                         $time, o_cell_material, o_moved, o_move_kind);
                n_errors++;
            end else begin
                head = awaited_results.pop_front();
                n_checked++;
                if (o_cell_material !== head.mat)
                    report_field("cell_material", head.mat, o_cell_material);
                if (o_moved !== head.moved)
                    report_field("moved", head.moved, o_moved);
                if (o_move_kind !== head.kind)
                    report_field("move_kind", head.kind, o_move_kind);
            end
        end
    end

    // receiver with random stalls and one long hold-off
    initial begin
        i_out_ready = 1'b0;
        forever begin
            @(negedge i_clk);
            if (drain_hold_req) begin
                drain_hold_req = 1'b0;
                i_out_ready <= 1'b0;
                repeat (HOLD_CYCLES) @(negedge i_clk);
            end
            i_out_ready <= ($urandom_range(99) >= rx_idle_pct);
        end
    end

    always @(posedge i_clk) begin
        if ((i_in_valid && o_in_ready === 1'b1) || (o_out_valid === 1'b1 && i_out_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles == WATCHDOG_LIMIT) begin
            $display("%0t: watchdog expired, %0d results outstanding",
                     $time, awaited_results.size());
            $display("tb: failure");
            $finish;
        end
    end

    initial begin
        cell_op_t op;
        int       ph;
        int       k;
        i_rst_n          = 1'b0;
        i_cfg_we         = 1'b0;
        i_cfg_index      = CFG_SAND_DENS;
        i_cfg_data       = 8'd0;
        i_in_valid       = 1'b0;
        i_cmd            = CMD_READ;
        i_cell_x         = 8'd0;
        i_cell_y         = 8'd0;
        i_paint_material = MAT_EMPTY;
        i_rand_dir       = DIR_ZERO;
        foreach (cell_store[i]) cell_store[i] = MAT_EMPTY;
        sand_dens  = 8'd2;
        water_dens = 8'd1;
        brick_dens = 8'd99;

        row_known(CMD_READ,   0,   0,   MAT_EMPTY, DIR_ZERO,  MAT_EMPTY);
        row_known(CMD_READ,   255, 255, MAT_EMPTY, DIR_ZERO,  MAT_EMPTY);
        row_known(CMD_ALIAS,  255, 0,   MAT_SAND,  DIR_PLUS,  MAT_EMPTY);
        row_known(CMD_PAINT,  255, 255, MAT_SAND,  DIR_ZERO,  MAT_EMPTY);
        // bottom-right corner: floor and right wall block every move
        row_known(CMD_UPDATE, 255, 255, MAT_EMPTY, DIR_PLUS,  MAT_SAND);
        row_known(CMD_PAINT,  0,   255, MAT_WATER, DIR_ZERO,  MAT_EMPTY);
        // saturated direction at the left wall
        row_known(CMD_UPDATE, 0,   255, MAT_EMPTY, DIR_SAT,   MAT_WATER);
        row(CMD_PAINT,  10, 9, MAT_BRICK, DIR_ZERO);
        row(CMD_PAINT,  10, 8, MAT_SAND,  DIR_ZERO);
        row(CMD_UPDATE, 10, 8, MAT_EMPTY, DIR_MINUS);
        row(CMD_READ,   9,  9, MAT_EMPTY, DIR_ZERO);
        row(CMD_PAINT,  20, 9, MAT_BRICK, DIR_ZERO);
        row(CMD_PAINT,  20, 8, MAT_SAND,  DIR_ZERO);
        row(CMD_UPDATE, 20, 8, MAT_EMPTY, DIR_ZERO);
        row(CMD_PAINT,  30, 9, MAT_BRICK, DIR_ZERO);
        row(CMD_PAINT,  29, 9, MAT_BRICK, DIR_ZERO);
        row(CMD_PAINT,  30, 8, MAT_WATER, DIR_ZERO);
        row(CMD_UPDATE, 30, 8, MAT_EMPTY, DIR_SAT);
        row(CMD_PAINT,  50, 9, MAT_WATER, DIR_ZERO);
        row(CMD_PAINT,  50, 8, MAT_SAND,  DIR_ZERO);
        row(CMD_UPDATE, 50, 8, MAT_EMPTY, DIR_ZERO);
        row(CMD_UPDATE, 50, 8, MAT_EMPTY, DIR_PLUS);
        row(CMD_UPDATE, 10, 9, MAT_EMPTY, DIR_PLUS);
        row_known(CMD_UPDATE, 100, 100, MAT_SAND, DIR_MINUS, MAT_EMPTY);
        row_known(CMD_PAINT,  255, 255, MAT_EMPTY, DIR_ZERO, MAT_SAND);

        tx_idle_pct = 23;
        rx_idle_pct = 78;
        repeat (4) @(negedge i_clk);
        i_rst_n <= 1'b1;
        foreach (directed_rows[i])
            send_cell_op(directed_rows[i].op, directed_rows[i].known, directed_rows[i].want);
        i_in_valid <= 1'b0;

        for (ph = 0; ph < PHASES; ph++) begin
            settle();
            case (ph)
                0: set_densities(8'd2, 8'd1, 8'd99);
                1: set_densities(8'd0, 8'd0, 8'd0);
                2: set_densities(8'd255, 8'd255, 8'd255);
                3: set_densities(8'd255, 8'd0, 8'd0);
                4: set_densities(8'd10, 8'd200, 8'd5);
                default: set_densities(8'($urandom_range(255)), 8'($urandom_range(255)),
                                       8'($urandom_range(255)));
            endcase
            tx_idle_pct = (ph < 2) ? 23 : (ph < 4) ? 78 : 0;
            rx_idle_pct = (ph < 2) ? 78 : (ph < 4) ? 23 : 0;
            if (ph == 1) drain_hold_req = 1'b1;
            for (k = 0; k < ITEMS_PER_PHASE; k++) begin
                if (k % 40 == 0) pick_window();
                op = random_cell_op();
                send_cell_op(op, 1'b0, '0);
            end
            i_in_valid <= 1'b0;
        end

        settle();
        $display("summary: %0d transactions sent, %0d results checked, %0d updates",
                 n_sent, n_checked, n_updates);
        $display("summary: moves %0d down, %0d diagonal, %0d sideways over %0d density settings",
                 n_down, n_diag, n_side, PHASES);
        if (n_errors == 0)
            $display("tb: success");
        else
            $display("tb: failure");
        $finish;
    end

endmodule

[falling_sand_cell_update.f]
+incdir+design
design/fsc_pkg.sv
design/fsc_grid_mem.sv
design/fsc_probe.sv
design/fsc_ctrl.sv
design/falling_sand_cell_update.sv
verif/tb_falling_sand_cell_update.sv
